/* rtl/u8u16_pkg.sv */
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int DEF_COUNT_WIDTH = 16;
    localparam int BYTE_W          = 8;
    localparam int UNIT_W          = 16;
    localparam int LIMIT_W         = 16;
    localparam int OUT_TDATA_W     = 40;

    localparam logic [7:0] CONT_MASK  = 8'h3f;
    localparam logic [7:0] LEAD2_MASK = 8'h1f;
    localparam logic [7:0] LEAD3_MASK = 8'h0f;

    typedef enum logic [1:0] {
        STOP_NONE      = 2'd0,
        STOP_INVALID   = 2'd1,
        STOP_TRUNCATED = 2'd2,
        STOP_LIMIT     = 2'd3
    } stop_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_of_buffer;
        logic              last_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic              unit_valid;
        logic [UNIT_W-1:0] code_unit;
        logic              finished;
        logic [UNIT_W-1:0] unit_count;
        stop_t             stop_reason;
    } result_t;

endpackage

/* rtl/u8u16_in_reg.sv */
`timescale 1ns / 1ps

module u8u16_in_reg
    import u8u16_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    // The held item leaves whenever the decode stage advances, so a new item
    // can enter in the same cycle.
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

/* rtl/u8u16_core.sv */
`timescale 1ns / 1ps

module u8u16_core
    import u8u16_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [LIMIT_W-1:0] out_limit,
    input  logic               fire,
    input  in_item_t           item,
    output logic               has_result,
    output result_t            result
);

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [UNIT_W-1:0]      partial_reg, partial_next;
    logic [1:0]             awaited_reg, awaited_next;
    logic                   halted_reg, halted_next;
    stop_t                  reason_reg, reason_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic              emit;
    logic [UNIT_W-1:0] unit;
    logic [BYTE_W-1:0] b;

    assign b = item.data_byte;

    always_comb begin
        partial_next = partial_reg;
        awaited_next = awaited_reg;
        halted_next  = halted_reg;
        reason_next  = reason_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        unit         = '0;

        // A first byte restarts the buffer before the byte itself is decoded.
        if (item.first_of_buffer) begin
            partial_next = '0;
            awaited_next = '0;
            halted_next  = 1'b0;
            reason_next  = STOP_NONE;
            count_next   = '0;
        end

        if (!halted_next) begin
            if (awaited_next != 2'd0) begin
                partial_next = {partial_next[UNIT_W-7:0], b[5:0]};
                awaited_next = awaited_next - 2'd1;
                if (awaited_next == 2'd0) begin
                    emit         = 1'b1;
                    unit         = partial_next;
                    partial_next = '0;
                end
            end else begin
                unique case (b) inside
                    8'b0???????: begin
                        emit = 1'b1;
                        unit = UNIT_W'(b);
                    end
                    8'b110?????: begin
                        partial_next = UNIT_W'(b & LEAD2_MASK);
                        awaited_next = 2'd1;
                    end
                    8'b1110????: begin
                        partial_next = UNIT_W'(b & LEAD3_MASK);
                        awaited_next = 2'd2;
                    end
                    default: begin
                        halted_next = 1'b1;
                        reason_next = STOP_INVALID;
                    end
                endcase
            end

            if (emit) begin
                if (count_next != '1) begin
                    count_next = count_next + COUNT_WIDTH'(1);
                end
                if (out_limit != '0 && CMP_W'(count_next) == CMP_W'(out_limit)) begin
                    halted_next = 1'b1;
                    reason_next = STOP_LIMIT;
                end
            end
        end

        if (item.last_of_buffer) begin
            if (!halted_next && awaited_next != 2'd0) begin
                reason_next = STOP_TRUNCATED;
            end
            halted_next  = 1'b1;
            awaited_next = '0;
            partial_next = '0;
        end
    end

    always_comb begin
        has_result         = emit || item.last_of_buffer;
        result.unit_valid  = emit;
        result.code_unit   = unit;
        result.finished    = item.last_of_buffer;
        result.unit_count  = UNIT_W'(count_next);
        result.stop_reason = item.last_of_buffer ? reason_next : STOP_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            awaited_reg <= '0;
            halted_reg  <= 1'b0;
            reason_reg  <= STOP_NONE;
            count_reg   <= '0;
        end else if (fire) begin
            partial_reg <= partial_next;
            awaited_reg <= awaited_next;
            halted_reg  <= halted_next;
            reason_reg  <= reason_next;
            count_reg   <= count_next;
        end
    end

endmodule

/* rtl/u8u16_out_reg.sv */
`timescale 1ns / 1ps

module u8u16_out_reg
    import u8u16_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    result_t result_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            result_reg <= result;
        end
    end

endmodule

/* rtl/utf8_to_utf16_decoder_top.sv */
`timescale 1ns / 1ps

// UTF-8 to UTF-16 decoder for the basic multilingual plane. One UTF-8 byte
// enters per item and is held in an input register; short decode logic then
// folds it into a small sequence accumulator and loads the result register,
// so the block takes one item per cycle, limited only by downstream
// backpressure. A result item is produced for each completed 1-, 2- or
// 3-byte sequence and for every last-of-buffer byte, which reports the unit
// count and a stop reason (0 none, 1 invalid lead byte, 2 truncated
// sequence, 3 limit reached). Continuation bytes are not checked. A nonzero
// out_limit halts decoding once that many units have been produced; write it
// only while the block is idle.
module utf8_to_utf16_decoder_top
    import u8u16_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LIMIT_W-1:0]     cfg_data,     // out_limit

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,      // [7:0] data_byte
    input  logic                   s_tuser,      // [0] first_of_buffer
    input  logic                   s_tlast,      // last_of_buffer

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,      // [15:0] code_unit, [31:16] unit_count,
                                                 // [33:32] stop_reason, [39:34] zero
    output logic                   m_tuser,      // [0] unit_valid
    output logic                   m_tlast       // finished
);

    logic [LIMIT_W-1:0] limit_reg;
    in_item_t           s_item;
    in_item_t           item;
    logic               item_valid;
    logic               can_load;
    logic               fire;
    logic               has_result;
    result_t            result;
    result_t            m_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    assign s_item.data_byte       = s_tdata;
    assign s_item.first_of_buffer = s_tuser;
    assign s_item.last_of_buffer  = s_tlast;

    // An item is decoded in the cycle that it moves on from the input register.
    assign fire = item_valid && can_load;

    u8u16_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    u8u16_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .out_limit  (limit_reg),
        .fire       (fire),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    u8u16_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && has_result),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {6'd0, m_result.stop_reason, m_result.unit_count, m_result.code_unit};
    assign m_tuser = m_result.unit_valid;
    assign m_tlast = m_result.finished;

endmodule
